// ===== hw/rtl/olir_pkg.sv =====
// ----------------------------------------------------------------------------
// olir_pkg
// types and constants for the ordered list with insert, remove, get, reverse
// ----------------------------------------------------------------------------
package olir_pkg;

  // fixed field widths of the stream words
  localparam int POS_W       = 5;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // defaults for the top level parameters
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_GET     = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_REM_CAP,
    S_REM_RD,
    S_REM_WR,
    S_GET_CAP,
    S_REV_RD_L,
    S_REV_RD_R,
    S_REV_WR_L,
    S_REV_WR_R,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/ordered_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// ordered list of up to DEPTH words with insert, remove, get and reverse
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, single-port-read memory with a
// registered read, and a small sequencer moves entries one at a time through
// that one memory port, so one request word is worked on at a time and
// in_tready is high only while the sequencer is idle. An accepted request
// is decoded; a flagged request or a reverse of fewer than two entries goes
// straight on to the output register, get reads its entry first, insert moves
// entries up from the end and then writes the value, remove keeps its entry
// and then moves later entries down, and reverse swaps the two ends walking
// inward. Each entry move is a read and a write, each swap two reads and two
// writes, all through the single memory port.
// The output register lets the next request word be accepted while the
// previous result still waits for out_tready. The list memory has no reset:
// only entries below the count are ever read, and all of those were written.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove
  import olir_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // op[1:0], position[6:2], value_in[38:7]
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // value_out[31:0], count[36:32], status[38:37]
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // list storage
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // sequencer state
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;       // moving index, or low end of reverse
  logic [AW-1:0]     hi_r, hi_nxt;         // high end of reverse
  logic [DATA_W-1:0] tmp_r, tmp_nxt;       // low entry held during a swap
  logic [DATA_W-1:0] res_value_r, res_value_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // output register
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  status_t             out_status_r, out_status_nxt;

  // position against count, both widened to a common width
  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] cnt_cmp;
  logic [AW-1:0]    pos_a;

  assign pos_cmp = CMP_W'(pos_r);
  assign cnt_cmp = CMP_W'(count_r);
  assign pos_a   = AW'(pos_r);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    hi_r         <= hi_nxt;
    tmp_r        <= tmp_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // next state and memory control
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    hi_nxt         = hi_r;
    tmp_nxt        = tmp_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    count_nxt      = count_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata_r;
    mem_re         = 1'b0;
    mem_raddr      = idx_r;
    in_tready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tdata[1:0]);
          pos_nxt   = in_tdata[2 +: POS_W];
          val_nxt   = DATA_W'(in_tdata[2 + POS_W +: VALUE_W]);
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_value_nxt  = '0;
        res_status_nxt = STAT_OK;
        state_nxt      = S_FINISH;
        case (op_r)
          OP_INSERT: begin
            // full check comes before the range check
            if (count_r == CNT_W'(DEPTH)) begin
              res_status_nxt = STAT_FULL;
            end else if (pos_cmp > cnt_cmp) begin
              res_status_nxt = STAT_RANGE;
            end else begin
              idx_nxt   = AW'(count_r);
              state_nxt = S_INS_RD;
            end
          end
          OP_REMOVE: begin
            if (pos_cmp >= cnt_cmp) begin
              res_status_nxt = STAT_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = pos_a;
              idx_nxt   = pos_a;
              state_nxt = S_REM_CAP;
            end
          end
          OP_GET: begin
            if (pos_cmp >= cnt_cmp) begin
              res_status_nxt = STAT_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = pos_a;
              state_nxt = S_GET_CAP;
            end
          end
          default: begin
            // reverse; zero or one entry stays as it is
            if (count_r > CNT_W'(1)) begin
              idx_nxt   = '0;
              hi_nxt    = AW'(count_r - CNT_W'(1));
              state_nxt = S_REV_RD_L;
            end
          end
        endcase
      end

      // insert: move entries up from the end down to the position
      S_INS_RD: begin
        if (idx_r == pos_a) begin
          mem_we    = 1'b1;
          mem_waddr = pos_a;
          mem_wdata = val_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - AW'(1);
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        idx_nxt   = idx_r - AW'(1);
        state_nxt = S_INS_RD;
      end

      // remove: keep the entry, then move later entries down
      S_REM_CAP: begin
        res_value_nxt = mem_rdata_r;
        state_nxt     = S_REM_RD;
      end

      S_REM_RD: begin
        if ((CNT_W'(idx_r) + CNT_W'(1)) >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(1);
          state_nxt = S_REM_WR;
        end
      end

      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        idx_nxt   = idx_r + AW'(1);
        state_nxt = S_REM_RD;
      end

      S_GET_CAP: begin
        res_value_nxt = mem_rdata_r;
        state_nxt     = S_FINISH;
      end

      // reverse: swap low and high ends, walking inward
      S_REV_RD_L: begin
        if (idx_r >= hi_r) begin
          state_nxt = S_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r;
          state_nxt = S_REV_RD_R;
        end
      end

      S_REV_RD_R: begin
        tmp_nxt   = mem_rdata_r;
        mem_re    = 1'b1;
        mem_raddr = hi_r;
        state_nxt = S_REV_WR_L;
      end

      S_REV_WR_L: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        state_nxt = S_REV_WR_R;
      end

      S_REV_WR_R: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = tmp_r;
        idx_nxt   = idx_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        state_nxt = S_REV_RD_L;
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_value_nxt  = VALUE_W'(res_value_r);
          out_count_nxt  = COUNT_W'(count_r);
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_status_r, out_count_r, out_value_r};

endmodule
